FILE: rtl/tpq_pkg.sv
// Package: shared types and constants of the triage priority queue.
`default_nettype none

package tpq_pkg;

  // Number of distinct valid priority levels, 1 (most urgent) to 5
  localparam int unsigned NUM_PRIO = 5;
  localparam logic [2:0]  PRIO_MIN = 3'd1;
  localparam logic [2:0]  PRIO_MAX = 3'd5;

  // Ticket counter value after reset
  localparam logic [15:0] TICKET_RESET = 16'd1000;

  typedef enum logic {
    CMD_INSERT  = 1'b0,
    CMD_EXTRACT = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_PUSH
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic latch;     // capture the accepted request
    logic exec;      // update queue state, access RAM
    logic load_out;  // move result into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_busy;  // output register holds a result not taken this cycle
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/tpq_in_if.sv
// Interface: request channel (command and priority).
`default_nettype none

interface tpq_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [2:0] priority_req;

  modport source (output valid, output command, output priority_req, input ready);
  modport sink   (input valid, input command, input priority_req, output ready);
endinterface

`default_nettype wire

FILE: rtl/tpq_out_if.sv
// Interface: result channel (status, ticket, priority, occupancy).
`default_nettype none

interface tpq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] ticket;
  logic [2:0]  served_priority;
  logic [7:0]  occupancy;

  modport source (output valid, output status, output ticket, output served_priority,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input ticket, input served_priority,
                  input occupancy, output ready);
endinterface

`default_nettype wire

FILE: rtl/tpq_cfg_if.sv
// Interface: configuration write channel for the ticket start value.
`default_nettype none

interface tpq_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/tpq_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module tpq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 640
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tpq_ctrl.sv
// Controller: sequences accept, execute and result load for each request.
`default_nettype none

module tpq_ctrl import tpq_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_PUSH;
      end
      S_PUSH: begin
        if (!status_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      S_PUSH: begin
        cmd_o.load_out = !status_i.out_busy;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/tpq_datapath.sv
// Datapath: per-priority ticket FIFOs in one RAM, counters and result register.
`default_nettype none

module tpq_datapath import tpq_pkg::*; #(
  parameter int unsigned CAPACITY = 128
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      req_command_i,
  input  wire logic [2:0] req_priority_i,
  tpq_out_if.source      rsp_o,
  tpq_cfg_if.sink        cfg_i,
  input  wire ctrl_cmd_t cmd_i,
  output dp_status_t     status_o
);

  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned PW    = $clog2(CAPACITY);
  localparam int unsigned DEPTH = NUM_PRIO * CAPACITY;
  localparam int unsigned AW    = $clog2(DEPTH);

  // Captured request
  cmd_e       cmd_q, cmd_d;
  logic [2:0] prio_q, prio_d;

  // Queue bookkeeping
  logic [CW-1:0] count_q, count_d;
  logic [15:0]   next_ticket_q, next_ticket_d;
  logic [PW-1:0] head_q [NUM_PRIO];
  logic [PW-1:0] head_d [NUM_PRIO];
  logic [PW-1:0] tail_q [NUM_PRIO];
  logic [PW-1:0] tail_d [NUM_PRIO];
  logic [CW-1:0] fill_q [NUM_PRIO];
  logic [CW-1:0] fill_d [NUM_PRIO];

  // Pending result
  status_e     res_status_q, res_status_d;
  logic [15:0] res_ticket_q, res_ticket_d;
  logic [2:0]  res_prio_q, res_prio_d;
  logic        res_from_ram_q, res_from_ram_d;

  // Output register
  logic        out_valid_q, out_valid_d;
  status_e     out_status_q, out_status_d;
  logic [15:0] out_ticket_q, out_ticket_d;
  logic [2:0]  out_prio_q, out_prio_d;
  logic [7:0]  out_occ_q, out_occ_d;

  // RAM port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_rdata;

  logic          full, prio_ok, any_held;
  logic [2:0]    prio_idx, sel_idx;
  logic [CW+7:0] occ_ext;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(CAPACITY - 1)) r = '0;
    else                        r = p + PW'(1);
    return r;
  endfunction

  function automatic logic [AW-1:0] slot_addr(input logic [2:0] idx, input logic [PW-1:0] p);
    logic [AW-1:0] base;
    base = AW'(idx) * AW'(CAPACITY);
    return base + AW'(p);
  endfunction

  // Lowest nonempty priority level
  always_comb begin
    sel_idx  = '0;
    any_held = 1'b0;
    for (int i = NUM_PRIO - 1; i >= 0; i--) begin
      if (fill_q[i] != '0) begin
        sel_idx  = 3'(i);
        any_held = 1'b1;
      end
    end
  end

  assign full     = (count_q == CW'(CAPACITY));
  assign prio_ok  = (prio_q >= PRIO_MIN) && (prio_q <= PRIO_MAX);
  assign prio_idx = prio_q - 3'd1;

  // Request execution and state update
  always_comb begin
    cmd_d          = cmd_q;
    prio_d         = prio_q;
    count_d        = count_q;
    next_ticket_d  = next_ticket_q;
    head_d         = head_q;
    tail_d         = tail_q;
    fill_d         = fill_q;
    res_status_d   = res_status_q;
    res_ticket_d   = res_ticket_q;
    res_prio_d     = res_prio_q;
    res_from_ram_d = res_from_ram_q;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = slot_addr(prio_idx, tail_q[prio_idx]);
    ram_raddr      = slot_addr(sel_idx, head_q[sel_idx]);

    if (cmd_i.latch) begin
      cmd_d  = cmd_e'(req_command_i);
      prio_d = req_priority_i;
    end

    if (cmd_i.exec) begin
      res_ticket_d   = '0;
      res_prio_d     = '0;
      res_from_ram_d = 1'b0;
      if (cmd_q == CMD_INSERT) begin
        priority if (full) begin
          res_status_d = ST_FULL;
        end else if (!prio_ok) begin
          res_status_d = ST_RANGE;
        end else begin
          // append ticket to the FIFO of this priority
          ram_we           = 1'b1;
          tail_d[prio_idx] = ptr_inc(tail_q[prio_idx]);
          fill_d[prio_idx] = fill_q[prio_idx] + CW'(1);
          count_d          = count_q + CW'(1);
          next_ticket_d    = next_ticket_q + 16'd1;
          res_status_d     = ST_OK;
          res_ticket_d     = next_ticket_q;
        end
      end else begin
        if (!any_held) begin
          res_status_d = ST_EMPTY;
        end else begin
          // pop the head of the most urgent nonempty FIFO
          ram_re          = 1'b1;
          head_d[sel_idx] = ptr_inc(head_q[sel_idx]);
          fill_d[sel_idx] = fill_q[sel_idx] - CW'(1);
          count_d         = count_q - CW'(1);
          res_status_d    = ST_OK;
          res_prio_d      = sel_idx + 3'd1;
          res_from_ram_d  = 1'b1;
        end
      end
    end

    // ticket start write reloads the counter
    if (cfg_i.valid) begin
      next_ticket_d = cfg_i.data;
    end
  end

  // Output register
  assign occ_ext = {8'd0, count_q};

  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_ticket_d = out_ticket_q;
    out_prio_d   = out_prio_q;
    out_occ_d    = out_occ_q;
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load_out) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_ticket_d = res_from_ram_q ? ram_rdata : res_ticket_q;
      out_prio_d   = res_prio_q;
      out_occ_d    = occ_ext[7:0];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      next_ticket_q <= TICKET_RESET;
      out_valid_q   <= 1'b0;
      for (int i = 0; i < NUM_PRIO; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      count_q       <= count_d;
      next_ticket_q <= next_ticket_d;
      out_valid_q   <= out_valid_d;
      head_q        <= head_d;
      tail_q        <= tail_d;
      fill_q        <= fill_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q          <= cmd_d;
    prio_q         <= prio_d;
    res_status_q   <= res_status_d;
    res_ticket_q   <= res_ticket_d;
    res_prio_q     <= res_prio_d;
    res_from_ram_q <= res_from_ram_d;
    out_status_q   <= out_status_d;
    out_ticket_q   <= out_ticket_d;
    out_prio_q     <= out_prio_d;
    out_occ_q      <= out_occ_d;
  end

  tpq_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (next_ticket_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cfg_i.ready           = 1'b1;
  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.status          = out_status_q;
  assign rsp_o.ticket          = out_ticket_q;
  assign rsp_o.served_priority = out_prio_q;
  assign rsp_o.occupancy       = out_occ_q;
  assign status_o.out_busy     = out_valid_q && !rsp_o.ready;

endmodule

`default_nettype wire

FILE: rtl/triage_priority_queue_unit.sv
// Top level: stable minimum-priority queue with ticket numbering.
`default_nettype none

// Each request goes through accept, execute and result load. Inserts append
// a ticket to one of five per-priority FIFOs held in a single RAM; extracts pop
// the head of the most urgent nonempty FIFO through the registered RAM read in
// execute. The output register frees the request side, so the next request
// is accepted while a result still waits; when the result side stalls, the
// result load waits for it. The RAM needs no clearing after reset: FIFO
// pointers and fill counts reset, and only written slots are ever read.
// A write on the configuration channel reloads the ticket counter.
module triage_priority_queue_unit import tpq_pkg::*; #(
  parameter int unsigned CAPACITY = 128
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tpq_in_if.sink    req_i,
  tpq_out_if.source rsp_o,
  tpq_cfg_if.sink   cfg_i
);

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  tpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  tpq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_command_i  (req_i.command),
    .req_priority_i (req_i.priority_req),
    .rsp_o          (rsp_o),
    .cfg_i          (cfg_i),
    .cmd_i          (ctrl_cmd),
    .status_o       (dp_status)
  );

endmodule

`default_nettype wire

FILE: tb/tpq_checker.sv
// Checker: predicts queue results from observed requests and compares them.
`timescale 1ns / 1ps

module tpq_checker import tpq_pkg::*; #(
  parameter int unsigned CAPACITY = 128
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tpq_in_if         req_i,
  tpq_out_if        rsp_i,
  tpq_cfg_if        cfg_i,
  output int        errors_o,
  output int        pending_o,
  output int        held_o,
  output int        served_o,
  output int        full_seen_o,
  output int        empty_seen_o,
  output int        range_seen_o
);

  typedef struct packed {
    logic [2:0]  prio;
    logic [15:0] ticket;
  } entry_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] ticket;
    logic [2:0]  served;
    logic [7:0]  occ;
  } result_t;

  entry_t      waiting[$];  // held entries, arrival order
  result_t     due[$];      // predicted results, oldest first
  logic [15:0] ticket_next;
  result_t     want;

  // Apply one request to the predicted queue and return its result
  function automatic result_t triage_step(cmd_e cmd, logic [2:0] prio);
    result_t r;
    int      best;
    entry_t  e;
    r.status = ST_OK;
    r.ticket = '0;
    r.served = '0;
    if (cmd == CMD_INSERT) begin
      if (waiting.size() >= CAPACITY) begin
        r.status = ST_FULL;
      end else if (prio < PRIO_MIN || prio > PRIO_MAX) begin
        r.status = ST_RANGE;
      end else begin
        e.prio   = prio;
        e.ticket = ticket_next;
        waiting.push_back(e);
        r.ticket = ticket_next;
        ticket_next = ticket_next + 16'd1;
      end
    end else begin
      if (waiting.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        // strict compare keeps the earliest among equal priorities
        best = 0;
        for (int i = 1; i < waiting.size(); i++) begin
          if (waiting[i].prio < waiting[best].prio) best = i;
        end
        r.ticket = waiting[best].ticket;
        r.served = waiting[best].prio;
        waiting.delete(best);
      end
    end
    r.occ = 8'(waiting.size());
    return r;
  endfunction

  // Watch all three channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting.delete();
      due.delete();
      ticket_next  = TICKET_RESET;
      errors_o     = 0;
      served_o     = 0;
      full_seen_o  = 0;
      empty_seen_o = 0;
      range_seen_o = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) ticket_next = cfg_i.data;

      // result side: compare against the oldest prediction
      if (rsp_i.valid && rsp_i.ready) begin
        if (due.size() == 0) begin
          $display("%0t: unexpected result status %0d ticket %0d prio %0d occ %0d",
                   $time, rsp_i.status, rsp_i.ticket, rsp_i.served_priority,
                   rsp_i.occupancy);
          errors_o++;
        end else begin
          want = due.pop_front();
          if (rsp_i.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, rsp_i.status);
            errors_o++;
          end
          if (rsp_i.ticket !== want.ticket) begin
            $display("%0t: ticket expected %0d actual %0d",
                     $time, want.ticket, rsp_i.ticket);
            errors_o++;
          end
          if (rsp_i.served_priority !== want.served) begin
            $display("%0t: served_priority expected %0d actual %0d",
                     $time, want.served, rsp_i.served_priority);
            errors_o++;
          end
          if (rsp_i.occupancy !== want.occ) begin
            $display("%0t: occupancy expected %0d actual %0d",
                     $time, want.occ, rsp_i.occupancy);
            errors_o++;
          end
        end
      end

      // request side: predict and queue the result
      if (req_i.valid && req_i.ready) begin
        want = triage_step(cmd_e'(req_i.command), req_i.priority_req);
        due.push_back(want);
        case (want.status)
          ST_FULL:  full_seen_o++;
          ST_EMPTY: empty_seen_o++;
          ST_RANGE: range_seen_o++;
          default:  if (req_i.command == CMD_EXTRACT) served_o++;
        endcase
      end
    end
    pending_o = due.size();
    held_o    = waiting.size();
  end

endmodule

FILE: tb/tb.sv
// Testbench top: stimulus, idling control and verdict for the triage queue.
`timescale 1ns / 1ps

module tb import tpq_pkg::*; ();

  localparam int unsigned CAPACITY    = 128;
  localparam int          STALL_LIMIT = 2000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  tpq_in_if  req();
  tpq_out_if rsp();
  tpq_cfg_if cfg();

  int errors, pending, held, served, full_seen, empty_seen, range_seen;
  int gap_pct   = 0;
  int stall_pct = 0;
  int sent      = 0;
  int cfg_writes = 0;
  int idle_cycles = 0;

  triage_priority_queue_unit #(.CAPACITY(CAPACITY)) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req),
    .rsp_o  (rsp),
    .cfg_i  (cfg)
  );

  tpq_checker #(.CAPACITY(CAPACITY)) checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_i        (req),
    .rsp_i        (rsp),
    .cfg_i        (cfg),
    .errors_o     (errors),
    .pending_o    (pending),
    .held_o       (held),
    .served_o     (served),
    .full_seen_o  (full_seen),
    .empty_seen_o (empty_seen),
    .range_seen_o (range_seen)
  );

  always #4 clk = ~clk;

  // Result side backpressure
  always @(negedge clk) begin
    rsp.ready = ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: cycles without any accepted transfer
  always @(posedge clk) begin
    if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Priority pick: mostly legal, bad_pct percent out of range
  function automatic logic [2:0] pick_prio(int bad_pct);
    if ($urandom_range(99) < bad_pct) begin
      case ($urandom_range(2))
        0:       return 3'd0;
        1:       return 3'd6;
        default: return 3'd7;
      endcase
    end
    return 3'($urandom_range(PRIO_MIN, PRIO_MAX));
  endfunction

  // One request; called and returns at a falling edge, valid left high
  task automatic send(cmd_e cmd, logic [2:0] prio);
    while ($urandom_range(99) < gap_pct) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.valid        = 1'b1;
    req.command      = cmd;
    req.priority_req = prio;
    do @(posedge clk); while (!req.ready);
    sent++;
    @(negedge clk);
  endtask

  // Stop sending and wait until every predicted result has arrived
  task automatic wait_drained();
    req.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_ticket_start(logic [15:0] start);
    cfg.valid = 1'b1;
    cfg.data  = start;
    do @(posedge clk); while (!cfg.ready);
    cfg_writes++;
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic fill_to_full(int extra);
    while (held < CAPACITY) send(CMD_INSERT, pick_prio(0));
    repeat (extra) send(CMD_INSERT, pick_prio(30));
  endtask

  task automatic drain_to_empty(int extra);
    while (held > 0) send(CMD_EXTRACT, 3'($urandom_range(7)));
    repeat (extra) send(CMD_EXTRACT, 3'($urandom_range(7)));
  endtask

  // One idling setting: reload tickets, fill and drain, then random sequences
  task automatic run_phase(int gap, int stall, logic [15:0] start, int quota);
    int first;
    int len;
    bit paused;
    wait_drained();
    load_ticket_start(start);
    gap_pct   = gap;
    stall_pct = stall;
    first     = sent;
    paused    = 1'b0;
    fill_to_full($urandom_range(1, 3));
    drain_to_empty($urandom_range(1, 2));
    while (sent - first < quota) begin
      // hold off once until the queue of results is empty
      if (!paused && sent - first >= quota / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      len = $urandom_range(1, 40);
      case ($urandom_range(9))
        0, 1, 2, 3: repeat (len) send(CMD_INSERT, pick_prio(10));
        4, 5, 6:    repeat (len) send(CMD_EXTRACT, 3'($urandom_range(7)));
        7:          fill_to_full($urandom_range(1, 3));
        8:          drain_to_empty($urandom_range(1, 2));
        default: begin
          repeat ($urandom_range(1, 10)) begin
            send(cmd_e'($urandom_range(1)), 3'($urandom_range(7)));
          end
        end
      endcase
    end
  endtask

  initial begin
    req.valid        = 1'b0;
    req.command      = CMD_INSERT;
    req.priority_req = 3'd0;
    rsp.ready        = 1'b0;
    cfg.valid        = 1'b0;
    cfg.data         = 16'd0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty extract, reset ticket value, range errors, wrap, ties
    send(CMD_EXTRACT, 3'd0);
    send(CMD_INSERT, 3'd2);
    wait_drained();
    load_ticket_start(16'd65534);
    send(CMD_INSERT, 3'd0);
    send(CMD_INSERT, 3'd6);
    send(CMD_INSERT, 3'd7);
    send(CMD_INSERT, 3'd3);
    send(CMD_INSERT, 3'd1);
    send(CMD_INSERT, 3'd5);
    send(CMD_INSERT, 3'd1);
    send(CMD_INSERT, 3'd3);
    send(CMD_INSERT, 3'd2);
    send(CMD_INSERT, 3'd4);
    send(CMD_INSERT, 3'd5);
    repeat (10) send(CMD_EXTRACT, 3'($urandom_range(7)));

    // Random: one phase per idling setting
    run_phase(0, 0, 16'd0, 400);
    run_phase(50, 0, 16'hFFF0, 400);
    run_phase(0, 50, 16'($urandom), 400);
    run_phase(17, 17, 16'hFFFF, 400);

    wait_drained();
    repeat (20) @(posedge clk);

    $display("summary: %0d requests over %0d ticket_start settings, %0d entries served",
             sent, cfg_writes + 1, served);
    $display("summary: %0d full inserts, %0d empty extracts, %0d out-of-range priorities",
             full_seen, empty_seen, range_seen);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/tpq_pkg.sv
rtl/tpq_in_if.sv
rtl/tpq_out_if.sv
rtl/tpq_cfg_if.sv
rtl/tpq_ram.sv
rtl/tpq_ctrl.sv
rtl/tpq_datapath.sv
rtl/triage_priority_queue_unit.sv
tb/tpq_checker.sv
tb/tb.sv
